>>> rtl/geo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geo_pkg
// Shared widths, stage map, constants and the arctangent table of the
// geodetic to ECEF pipeline.
// ----------------------------------------------------------------------------
package geo_pkg;

  localparam int ANGLE_WIDTH = 32;
  localparam int TRIG_STAGES = 28;

  localparam int ANG_W  = 32;
  localparam int HGT_W  = 32;
  localparam int AXIS_W = 33;
  localparam int ECC_W  = 32;
  localparam int OUT_W  = 35;
  localparam int Q30    = 30;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MAJOR_AXIS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ECC_SQ     = 1'd1;

  localparam int TRIG_W = 33;
  localparam int ZW     = 34;
  localparam int CORDIC_LAT = TRIG_STAGES + 1;
  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic [ANG_W-1:0] ANGLE_KEEP =
    ~((ANG_W'(1) << (ANG_W - ANGLE_WIDTH)) - ANG_W'(1));

  localparam int D_W          = Q30 + 1;
  localparam int RAD_W        = D_W + Q30;
  localparam int SQRT_STAGES  = (RAD_W + 1) / 2;
  localparam int ROOT_W       = Q30 + 1;
  localparam int ROOT_MIN_LOG = Q30 / 2;

  localparam int NUM_W      = AXIS_W + Q30 + 1;
  localparam int QUO_W      = NUM_W - ROOT_MIN_LOG;
  localparam int DIV_STAGES = QUO_W + 1;
  localparam int NH_W       = QUO_W - ECC_W;

  localparam int MUL_W = 56;
  localparam longint OUT_LIMIT = 64'd17179869183;

  localparam int ST_CORD     = CORDIC_LAT;
  localparam int ST_M1       = ST_CORD + 1;
  localparam int ST_M2       = ST_CORD + 2;
  localparam int ST_M3       = ST_CORD + 3;
  localparam int ST_M4       = ST_CORD + 4;
  localparam int ST_SQ_END   = ST_M4 + SQRT_STAGES;
  localparam int ST_DIV_END  = ST_SQ_END + DIV_STAGES;
  localparam int ST_P1       = ST_DIV_END + 1;
  localparam int ST_P2       = ST_DIV_END + 2;
  localparam int ST_P3       = ST_DIV_END + 3;
  localparam int ST_T1       = ST_DIV_END + 4;
  localparam int ST_T2       = ST_DIV_END + 5;
  localparam int ST_U1       = ST_DIV_END + 6;
  localparam int ST_U2       = ST_DIV_END + 7;
  localparam int ST_OUT      = ST_DIV_END + 8;

  typedef struct packed {
    logic signed [HGT_W-1:0]  h;
    logic signed [TRIG_W-1:0] cb;
    logic signed [TRIG_W-1:0] sb;
    logic signed [TRIG_W-1:0] cl;
    logic signed [TRIG_W-1:0] sl;
  } side_t;

  function automatic logic [31:0] atan_entry(input int i);
    logic [31:0] r;
    unique case (i)
      0:  r = 32'h20000000;
      1:  r = 32'h12E4051E;
      2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;
      4:  r = 32'h028B0D43;
      5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;
      7:  r = 32'h00517C55;
      8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;
      10: r = 32'h000A2F98;
      11: r = 32'h000517CC;
      12: r = 32'h00028BE6;
      13: r = 32'h000145F3;
      14: r = 32'h0000A2FA;
      15: r = 32'h0000517D;
      16: r = 32'h000028BE;
      17: r = 32'h0000145F;
      18: r = 32'h00000A30;
      19: r = 32'h00000518;
      20: r = 32'h0000028C;
      21: r = 32'h00000146;
      22: r = 32'h000000A3;
      23: r = 32'h00000051;
      24: r = 32'h00000029;
      25: r = 32'h00000014;
      26: r = 32'h0000000A;
      27: r = 32'h00000005;
      28: r = 32'h00000003;
      29: r = 32'h00000001;
      30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/geo_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geo_cordic
// Pipelined rotation CORDIC: quadrant fold, one micro-rotation per stage,
// Q30 cosine and sine out.
// ----------------------------------------------------------------------------
module geo_cordic (
  input  logic                               clk_i,
  input  logic [geo_pkg::CORDIC_LAT-1:0]     ld_i,
  input  logic [geo_pkg::ANG_W-1:0]          angle_i,
  output logic signed [geo_pkg::TRIG_W-1:0]  cos_o,
  output logic signed [geo_pkg::TRIG_W-1:0]  sin_o
);
  import geo_pkg::*;

  logic signed [TRIG_W-1:0] x_q [0:TRIG_STAGES];
  logic signed [TRIG_W-1:0] y_q [0:TRIG_STAGES];
  logic signed [ZW-1:0]     z_q [0:TRIG_STAGES];
  logic                     flip_q [0:TRIG_STAGES];

  logic [ANG_W-1:0] ang_quant;
  logic             flip_d;

  assign ang_quant = angle_i & ANGLE_KEEP;
  assign flip_d    = ang_quant[ANG_W-1] ^ ang_quant[ANG_W-2];

  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      x_q[0]    <= CORDIC_GAIN;
      y_q[0]    <= '0;
      z_q[0]    <= ZW'($signed({ang_quant[ANG_W-1] ^ flip_d, ang_quant[ANG_W-2:0]}));
      flip_q[0] <= flip_d;
    end
  end

  for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_rot
    logic signed [TRIG_W-1:0] dx, dy;
    logic signed [ZW-1:0]     at;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    assign at = ZW'(atan_entry(i));
    always_ff @(posedge clk_i) begin
      if (ld_i[i+1]) begin
        flip_q[i+1] <= flip_q[i];
        if (!z_q[i][ZW-1]) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - at;
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + at;
        end
      end
    end
  end

  assign cos_o = flip_q[TRIG_STAGES] ? -x_q[TRIG_STAGES] : x_q[TRIG_STAGES];
  assign sin_o = flip_q[TRIG_STAGES] ? -y_q[TRIG_STAGES] : y_q[TRIG_STAGES];

endmodule

>>> rtl/geo_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geo_isqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module geo_isqrt (
  input  logic                              clk_i,
  input  logic [geo_pkg::SQRT_STAGES-1:0]   ld_i,
  input  logic [geo_pkg::RAD_W-1:0]         rad_i,
  output logic [geo_pkg::ROOT_W-1:0]        root_o
);
  import geo_pkg::*;

  logic [RAD_W-1:0] rem_q [0:SQRT_STAGES-1];
  logic [RAD_W:0]   res_q [0:SQRT_STAGES-1];

  for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_bit
    logic [RAD_W-1:0] rem_in;
    logic [RAD_W:0]   res_in, bit_w, trial;
    if (i == 0) begin : g_first
      assign rem_in = rad_i;
      assign res_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign res_in = res_q[i-1];
    end
    assign bit_w = (RAD_W+1)'(1) << (2 * (SQRT_STAGES - 1 - i));
    assign trial = res_in + bit_w;
    always_ff @(posedge clk_i) begin
      if (ld_i[i]) begin
        if ({1'b0, rem_in} >= trial) begin
          rem_q[i] <= RAD_W'({1'b0, rem_in} - trial);
          res_q[i] <= (res_in >> 1) + bit_w;
        end else begin
          rem_q[i] <= rem_in;
          res_q[i] <= res_in >> 1;
        end
      end
    end
  end

  assign root_o = res_q[SQRT_STAGES-1][ROOT_W-1:0];

endmodule

>>> rtl/geo_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geo_div
// Pipelined restoring divider for the prime vertical radius, one quotient
// bit per stage, rounded half up.
// ----------------------------------------------------------------------------
module geo_div (
  input  logic                             clk_i,
  input  logic [geo_pkg::DIV_STAGES-1:0]   ld_i,
  input  logic [geo_pkg::AXIS_W-1:0]       axis_i,
  input  logic [geo_pkg::ROOT_W-1:0]       root_i,
  output logic [geo_pkg::QUO_W-1:0]        quo_o
);
  import geo_pkg::*;

  logic [NUM_W-1:0]  num;
  logic [ROOT_W-1:0] rem_q  [0:QUO_W];
  logic [QUO_W-1:0]  rest_q [0:QUO_W];
  logic [QUO_W-1:0]  quo_q  [0:QUO_W];
  logic [ROOT_W-1:0] den_q  [0:QUO_W];

  assign num = NUM_W'({axis_i, Q30'(0)}) + NUM_W'(root_i >> 1);

  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      rem_q[0]  <= ROOT_W'(num[NUM_W-1:QUO_W]);
      rest_q[0] <= num[QUO_W-1:0];
      quo_q[0]  <= '0;
      den_q[0]  <= root_i;
    end
  end

  for (genvar j = 1; j <= QUO_W; j++) begin : g_step
    logic [ROOT_W:0] rem_sh;
    logic            take;
    assign rem_sh = {rem_q[j-1], rest_q[j-1][QUO_W-1]};
    assign take   = rem_sh >= {1'b0, den_q[j-1]};
    always_ff @(posedge clk_i) begin
      if (ld_i[j]) begin
        rem_q[j]  <= take ? ROOT_W'(rem_sh - {1'b0, den_q[j-1]}) : rem_sh[ROOT_W-1:0];
        rest_q[j] <= rest_q[j-1] << 1;
        quo_q[j]  <= {quo_q[j-1][QUO_W-2:0], take};
        den_q[j]  <= den_q[j-1];
      end
    end
  end

  assign quo_o = quo_q[QUO_W];

endmodule

>>> rtl/geo_mulq30.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geo_mulq30
// Two-stage exact floor(v * c / 2^30): split v at bit 30, two partial
// products, then merge.
// ----------------------------------------------------------------------------
module geo_mulq30 (
  input  logic                              clk_i,
  input  logic [1:0]                        ld_i,
  input  logic signed [geo_pkg::MUL_W-1:0]  v_i,
  input  logic signed [geo_pkg::TRIG_W-1:0] c_i,
  output logic signed [geo_pkg::MUL_W-1:0]  p_o
);
  import geo_pkg::*;

  localparam int HI_W = MUL_W - Q30 + TRIG_W;
  localparam int LO_W = Q30 + 1 + TRIG_W;

  logic signed [HI_W-1:0]  hi_d, hi_q;
  logic signed [LO_W-1:0]  lo_d, lo_q;
  logic signed [LO_W-1:0]  sum;
  logic signed [MUL_W-1:0] p_q;

  assign hi_d = $signed(v_i[MUL_W-1:Q30]) * c_i;
  assign lo_d = $signed({1'b0, v_i[Q30-1:0]}) * c_i;
  assign sum  = LO_W'(hi_q) + (lo_q >>> Q30);

  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
    if (ld_i[1]) begin
      p_q <= sum[MUL_W-1:0];
    end
  end

  assign p_o = p_q;

endmodule

>>> rtl/geodetic_to_ecef.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geodetic_to_ecef
// Geodetic latitude, longitude and height to Earth-centred X, Y, Z.
// ----------------------------------------------------------------------------
// One point enters per clock while in_stall_o is low. The 28 CORDIC rotation
// stages, the one-bit-per-stage square root (31 stages) and the radius
// divider (50 stages) make up most of the latency. Every stage holds only
// when the stage after it is full and held, so bubbles close up under output
// stall. Angles are binary angles (2^31 = 180 degrees), lengths millimetres;
// results saturate at +/-(2^34-1). Write the ellipsoid registers only while
// the pipeline is empty.
// ----------------------------------------------------------------------------
module geodetic_to_ecef (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [geo_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [geo_pkg::AXIS_W-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [geo_pkg::ANG_W-1:0]    latitude_angle_i,
  input  logic signed [geo_pkg::ANG_W-1:0]    longitude_angle_i,
  input  logic signed [geo_pkg::HGT_W-1:0]    height_mm_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [geo_pkg::OUT_W-1:0]    x_mm_o,
  output logic signed [geo_pkg::OUT_W-1:0]    y_mm_o,
  output logic signed [geo_pkg::OUT_W-1:0]    z_mm_o
);
  import geo_pkg::*;

  localparam logic signed [MUL_W-1:0] SAT_HI = MUL_W'(OUT_LIMIT);
  localparam logic signed [MUL_W-1:0] SAT_LO = -SAT_HI;

  logic [AXIS_W-1:0] axis_q;
  logic [ECC_W-1:0]  ecc_q;

  logic [ST_OUT:1] valid_q;
  logic [ST_OUT:1] ld;
  side_t           side_q [1:ST_T2];

  logic signed [TRIG_W-1:0] cb, sb, cl, sl;
  logic [2*TRIG_W-1:0]      sq_d;
  logic [RAD_W-1:0]         sq_q;
  logic [D_W-1:0]           s2_q, es2_q, d_q;
  logic [ECC_W+D_W-1:0]     es2_prod;
  logic [ROOT_W-1:0]        root;
  logic [QUO_W-1:0]         n, n1_q, n2_q;
  logic [2*ECC_W-1:0]       plo_q;
  logic [NH_W+ECC_W-1:0]    phi_q;
  logic [QUO_W-1:0]         ne_q;
  logic signed [MUL_W-1:0]  rad2_q, rad3_q, zrad_q;
  logic signed [MUL_W-1:0]  t, xv, yv, zv, z1_q, z2_q;
  logic signed [OUT_W-1:0]  x_q, y_q, z_q;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q <= 33'd6378137000;
      ecc_q  <= 32'd28752143;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_MAJOR_AXIS: axis_q <= cfg_data_i;
        REG_ECC_SQ:     ecc_q  <= cfg_data_i[ECC_W-1:0];
        default: ;
      endcase
    end
  end

  // stage advance: a stage loads when empty or when the next one loads
  always_comb begin
    ld[ST_OUT] = !valid_q[ST_OUT] || !out_stall_i;
    for (int k = ST_OUT - 1; k >= 1; k--) begin
      ld[k] = !valid_q[k] || ld[k+1];
    end
  end

  assign in_stall_o = !ld[1];

  for (genvar k = 1; k <= ST_OUT; k++) begin : g_valid
    logic valid_d;
    if (k == 1) begin : g_in
      assign valid_d = in_valid_i;
    end else begin : g_pass
      assign valid_d = valid_q[k-1];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (ld[k]) begin
        valid_q[k] <= valid_d;
      end
    end
  end

  // trigonometry
  geo_cordic u_cordic_lat (
    .clk_i   (clk_i),
    .ld_i    (ld[ST_CORD:1]),
    .angle_i (latitude_angle_i),
    .cos_o   (cb),
    .sin_o   (sb)
  );

  geo_cordic u_cordic_lon (
    .clk_i   (clk_i),
    .ld_i    (ld[ST_CORD:1]),
    .angle_i (longitude_angle_i),
    .cos_o   (cl),
    .sin_o   (sl)
  );

  // side line: height, then the four trig values
  for (genvar k = 1; k <= ST_T2; k++) begin : g_side
    side_t side_d;
    if (k == 1) begin : g_in
      assign side_d = '{h: height_mm_i, cb: '0, sb: '0, cl: '0, sl: '0};
    end else if (k == ST_M1) begin : g_trig
      assign side_d = '{h: side_q[k-1].h, cb: cb, sb: sb, cl: cl, sl: sl};
    end else begin : g_pass
      assign side_d = side_q[k-1];
    end
    always_ff @(posedge clk_i) begin
      if (ld[k]) begin
        side_q[k] <= side_d;
      end
    end
  end

  // e2 sin^2 B and the radicand
  assign sq_d     = sb * sb;
  assign es2_prod = ecc_q * s2_q;

  always_ff @(posedge clk_i) begin
    if (ld[ST_M1]) begin
      sq_q <= sq_d[RAD_W-1:0];
    end
    if (ld[ST_M2]) begin
      s2_q <= (sq_q[RAD_W-1:Q30] > D_W'(1 << Q30)) ? D_W'(1 << Q30) : sq_q[RAD_W-1:Q30];
    end
    if (ld[ST_M3]) begin
      es2_q <= D_W'(es2_prod[ECC_W+D_W-1:ECC_W]);
    end
    if (ld[ST_M4]) begin
      d_q <= (es2_q >= D_W'(1 << Q30)) ? D_W'(1) : D_W'(1 << Q30) - es2_q;
    end
  end

  geo_isqrt u_isqrt (
    .clk_i  (clk_i),
    .ld_i   (ld[ST_SQ_END:ST_M4+1]),
    .rad_i  ({d_q, Q30'(0)}),
    .root_o (root)
  );

  geo_div u_div (
    .clk_i  (clk_i),
    .ld_i   (ld[ST_DIV_END:ST_SQ_END+1]),
    .axis_i (axis_q),
    .root_i (root),
    .quo_o  (n)
  );

  // N*e2, N+h and N(1-e2)+h
  always_ff @(posedge clk_i) begin
    if (ld[ST_P1]) begin
      n1_q  <= n;
      plo_q <= (2*ECC_W)'(n[ECC_W-1:0]) * (2*ECC_W)'(ecc_q);
      phi_q <= (NH_W+ECC_W)'(n[QUO_W-1:ECC_W]) * (NH_W+ECC_W)'(ecc_q);
    end
    if (ld[ST_P2]) begin
      n2_q   <= n1_q;
      ne_q   <= QUO_W'(phi_q) + QUO_W'(plo_q[2*ECC_W-1:ECC_W]);
      rad2_q <= $signed(MUL_W'(n1_q)) + MUL_W'(side_q[ST_P1].h);
    end
    if (ld[ST_P3]) begin
      rad3_q <= rad2_q;
      zrad_q <= $signed(MUL_W'(n2_q - ne_q)) + MUL_W'(side_q[ST_P2].h);
    end
  end

  geo_mulq30 u_mul_cb (
    .clk_i (clk_i),
    .ld_i  (ld[ST_T2:ST_T1]),
    .v_i   (rad3_q),
    .c_i   (side_q[ST_P3].cb),
    .p_o   (t)
  );

  geo_mulq30 u_mul_z (
    .clk_i (clk_i),
    .ld_i  (ld[ST_T2:ST_T1]),
    .v_i   (zrad_q),
    .c_i   (side_q[ST_P3].sb),
    .p_o   (zv)
  );

  geo_mulq30 u_mul_x (
    .clk_i (clk_i),
    .ld_i  (ld[ST_U2:ST_U1]),
    .v_i   (t),
    .c_i   (side_q[ST_T2].cl),
    .p_o   (xv)
  );

  geo_mulq30 u_mul_y (
    .clk_i (clk_i),
    .ld_i  (ld[ST_U2:ST_U1]),
    .v_i   (t),
    .c_i   (side_q[ST_T2].sl),
    .p_o   (yv)
  );

  // align z, saturate and hold the result
  always_ff @(posedge clk_i) begin
    if (ld[ST_U1]) begin
      z1_q <= zv;
    end
    if (ld[ST_U2]) begin
      z2_q <= z1_q;
    end
    if (ld[ST_OUT]) begin
      x_q <= (xv > SAT_HI) ? SAT_HI[OUT_W-1:0] :
             (xv < SAT_LO) ? SAT_LO[OUT_W-1:0] : xv[OUT_W-1:0];
      y_q <= (yv > SAT_HI) ? SAT_HI[OUT_W-1:0] :
             (yv < SAT_LO) ? SAT_LO[OUT_W-1:0] : yv[OUT_W-1:0];
      z_q <= (z2_q > SAT_HI) ? SAT_HI[OUT_W-1:0] :
             (z2_q < SAT_LO) ? SAT_LO[OUT_W-1:0] : z2_q[OUT_W-1:0];
    end
  end

  assign out_valid_o = valid_q[ST_OUT];
  assign x_mm_o      = x_q;
  assign y_mm_o      = y_q;
  assign z_mm_o      = z_q;

`ifndef ASSERT_OFF
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> valid_q[1])
    else $error("input stalled with first stage empty");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> valid_q[1])
    else $error("accepted transaction lost at first stage");

  a_radicand_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[ST_M4] |-> d_q != '0)
    else $error("radicand is zero");

  a_root_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[ST_SQ_END] |-> root >= ROOT_W'(1 << ROOT_MIN_LOG))
    else $error("square root below divider bound");
`endif

endmodule

>>> tb/geo_ecef_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geo_ecef_checker
// Watches the point and coordinate channels of geodetic_to_ecef, works out
// the X, Y, Z each accepted point should give and compares them in order.
// ----------------------------------------------------------------------------
module geo_ecef_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic                                cfg_ready_i,
  input  logic [geo_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [geo_pkg::AXIS_W-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic signed [geo_pkg::ANG_W-1:0]    latitude_angle_i,
  input  logic signed [geo_pkg::ANG_W-1:0]    longitude_angle_i,
  input  logic signed [geo_pkg::HGT_W-1:0]    height_mm_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic signed [geo_pkg::OUT_W-1:0]    x_mm_i,
  input  logic signed [geo_pkg::OUT_W-1:0]    y_mm_i,
  input  logic signed [geo_pkg::OUT_W-1:0]    z_mm_i,
  output int                                  fail_count_o,
  output int                                  pending_o,
  output int                                  coord_count_o
);
  import geo_pkg::*;

  typedef struct packed {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
  } ecef_t;

  ecef_t            ecef_queue[$];
  logic [AXIS_W-1:0] semi_major;
  logic [ECC_W-1:0]  ecc_sq;

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic void rotate(logic [31:0] ang, output longint c, output longint s);
    longint x, y, z, dx, dy;
    logic   flip;
    x = 652032874;
    y = 0;
    flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
    if (flip) ang = ang + 32'h80000000;
    z = longint'($signed(ang));
    for (int i = 0; i < TRIG_STAGES; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - longint'(atan_entry(i));
      end else begin
        x = x + dx; y = y - dy; z = z + longint'(atan_entry(i));
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint scale_q30(longint v, longint c);
    logic signed [127:0] p;
    p = 128'(signed'(v)) * 128'(signed'(c));
    return longint'(p >>> 30);
  endfunction

  function automatic logic [OUT_W-1:0] clamp(longint v);
    if (v > OUT_LIMIT) v = OUT_LIMIT;
    if (v < -OUT_LIMIT) v = -OUT_LIMIT;
    return v[OUT_W-1:0];
  endfunction

  function automatic ecef_t to_ecef(logic [31:0] lat, logic [31:0] lon, longint h);
    longint cb, sb, cl, sl, s2, d, radius, zrad, t;
    logic [63:0] es2, root, rem, bit_w, prime, ne;
    logic [127:0] wide;
    ecef_t r;
    rotate(lat & ANGLE_KEEP, cb, sb);
    rotate(lon & ANGLE_KEEP, cl, sl);
    s2 = longint'(64'(sb * sb) >> 30);
    if (s2 > 64'sd1073741824) s2 = 1073741824;
    es2 = (64'(ecc_sq) * 64'(s2)) >> 32;
    d = 1073741824 - longint'(es2);
    if (d < 1) d = 1;
    rem = 64'(d) << 30;
    root = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > rem) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (rem >= root + bit_w) begin
        rem = rem - (root + bit_w);
        root = (root >> 1) + bit_w;
      end else root = root >> 1;
      bit_w = bit_w >> 2;
    end
    wide = ((128'(semi_major) << 30) + 128'(root >> 1)) / 128'(root);
    prime = wide[63:0];
    wide = (128'(prime) * 128'(ecc_sq)) >> 32;
    ne = wide[63:0];
    radius = longint'(prime) + h;
    zrad = longint'(prime - ne) + h;
    t = scale_q30(radius, cb);
    r.x = clamp(scale_q30(t, cl));
    r.y = clamp(scale_q30(t, sl));
    r.z = clamp(scale_q30(zrad, sb));
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    ecef_t want;
    if (!rst_ni) begin
      semi_major    <= 33'd6378137000;
      ecc_sq        <= 32'd28752143;
      fail_count_o  <= 0;
      coord_count_o <= 0;
      pending_o     <= 0;
      ecef_queue.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_MAJOR_AXIS) semi_major <= cfg_data_i;
        else if (cfg_index_i == REG_ECC_SQ) ecc_sq <= cfg_data_i[ECC_W-1:0];
      end
      if (in_valid_i && !in_stall_i)
        ecef_queue.push_back(to_ecef(latitude_angle_i, longitude_angle_i,
                                     longint'(height_mm_i)));
      if (out_valid_i && !out_stall_i) begin
        coord_count_o <= coord_count_o + 1;
        if (ecef_queue.size() == 0) begin
          $display("%0t: unexpected transaction x=%0d y=%0d z=%0d",
                   $time, x_mm_i, y_mm_i, z_mm_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = ecef_queue.pop_front();
          if (want.x !== x_mm_i || want.y !== y_mm_i || want.z !== z_mm_i) begin
            $display("%0t: mismatch expected x=%0d y=%0d z=%0d actual x=%0d y=%0d z=%0d",
                     $time, want.x, want.y, want.z, x_mm_i, y_mm_i, z_mm_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      pending_o <= ecef_queue.size();
    end
  end
endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives geodetic points and ellipsoid settings into geodetic_to_ecef with
// random gaps and output stalls, and one long output hold-off in some phases.
// ----------------------------------------------------------------------------
module tb_top;
  import geo_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [AXIS_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [ANG_W-1:0] lat = '0;
  logic signed [ANG_W-1:0] lon = '0;
  logic signed [HGT_W-1:0] hgt = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [OUT_W-1:0] x_mm, y_mm, z_mm;
  int fails, pending, coords, points;
  int idle_cycles = 0;
  logic hold_off = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  geodetic_to_ecef uut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .latitude_angle_i(lat), .longitude_angle_i(lon), .height_mm_i(hgt),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .x_mm_o(x_mm), .y_mm_o(y_mm), .z_mm_o(z_mm)
  );

  geo_ecef_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .latitude_angle_i(lat), .longitude_angle_i(lon), .height_mm_i(hgt),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .x_mm_i(x_mm), .y_mm_i(y_mm), .z_mm_i(z_mm),
    .fail_count_o(fails), .pending_o(pending), .coord_count_o(coords)
  );

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("watchdog expired after %0d idle cycles", idle_cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  // per-transaction output wait, overridden by a long hold-off
  initial begin
    int wait_left;
    wait_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) wait_left = $urandom_range(0, 4);
      if (wait_left > 0) begin
        out_stall <= 1'b1;
        wait_left--;
      end else begin
        out_stall <= hold_off;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [AXIS_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_point(logic [31:0] b, logic [31:0] l, logic [31:0] h, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 4) : 0;
    if (gap != 0) in_valid <= 1'b0;
    repeat (gap) @(posedge clk);
    in_valid <= 1'b1;
    lat <= b;
    lon <= l;
    hgt <= h;
    do @(posedge clk); while (in_stall);
    points++;
  endtask

  task automatic release_valid();
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    @(posedge clk);
    while (pending != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    repeat (ST_OUT + 20) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_lat();
    case ($urandom_range(0, 5))
      0: return 32'h40000000;
      1: return 32'hC0000000;
      2: return $urandom();
      default: return 32'($signed($urandom_range(0, 32'h7FFFFFFF)) >>> 1);
    endcase
  endfunction

  task automatic random_phase(int count, bit with_hold);
    fork
      begin
        if (with_hold) begin
          repeat ($urandom_range(5, 30)) @(posedge clk);
          hold_off <= 1'b1;
          repeat (ST_OUT * 3) @(posedge clk);
          hold_off <= 1'b0;
        end
      end
      begin
        for (int i = 0; i < count; i++) begin
          logic [31:0] h;
          h = ($urandom_range(0, 3) == 0) ? $urandom()
              : 32'($signed($urandom_range(0, 40000000)) - 20000000);
          send_point(rand_lat(), $urandom(), h, $urandom_range(0, 3) != 0);
          if ($urandom_range(0, 4) == 0) release_valid();
        end
        release_valid();
      end
    join
    drain();
  endtask

  initial begin
    logic [31:0] lats[6];
    logic [31:0] lons[4];
    points = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    lats = '{32'h00000000, 32'h40000000, 32'hC0000000, 32'h20000000,
             32'h7FFFFFFF, 32'h80000000};
    lons = '{32'h00000000, 32'h7FFFFFFF, 32'h80000000, 32'h40000000};
    foreach (lats[i])
      send_point(lats[i], lons[i % 4], (i % 2) ? 32'sd2000000000 : -32'sd2000000000, 1'b0);
    send_point(32'h12345678, 32'hFFFFFFFF, 32'h7FFFFFFF, 1'b0);
    send_point(32'hEDCBA988, 32'h00000001, 32'h80000000, 1'b0);
    send_point(32'h40000000, 32'h00000000, 32'sd0, 1'b0);
    release_valid();
    drain();

    random_phase(250, 1'b1);

    write_reg(REG_MAJOR_AXIS, 33'd7000000000);
    write_reg(REG_ECC_SQ, 32'h80000000);
    random_phase(150, 1'b0);

    write_reg(REG_MAJOR_AXIS, 33'h1FFFFFFFF);
    write_reg(REG_ECC_SQ, 32'hFFFFFFFF);
    send_point(32'h40000000, 32'h00000000, 32'sd0, 1'b0);
    send_point(32'hC0000000, 32'h40000000, 32'sd2000000000, 1'b0);
    release_valid();
    random_phase(100, 1'b1);

    write_reg(REG_MAJOR_AXIS, 33'd6000000000);
    write_reg(REG_ECC_SQ, 32'd0);
    random_phase(150, 1'b0);

    write_reg(REG_MAJOR_AXIS, 33'd6378137000);
    write_reg(REG_ECC_SQ, 32'd28752143);
    random_phase(150, 1'b1);

    $display("Sent %0d points over five ellipsoid settings, %0d coordinates checked.",
             points, coords);
    if (fails == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
